// ===== rtl/core/lca_pkg.sv =====
// Shared constants, types and the helper function of the lowest common ancestor core.
package lca_pkg;

  localparam int NODES     = 1024;
  localparam int LEVELS    = 10;
  localparam int NODE_W    = 10;
  localparam int NIDX_W    = $clog2(NODES);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DEPTH_W   = LEVELS;
  localparam int ANC_DEPTH = NODES << LVL_W;

  localparam logic ACT_QUERY = 1'b1;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [LVL_W-1:0]   lvl_t;

  localparam depth_t DEPTH_MAX = '1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ATT0,
    OP_ATT_RD,
    OP_ATT_WR,
    OP_ATT_DEP,
    OP_Q_DEP,
    OP_Q_DIFF,
    OP_Q_LIFT_RD,
    OP_Q_LIFT_WR,
    OP_Q_SKIP,
    OP_Q_EQ,
    OP_Q_UP_RD,
    OP_Q_UP_WR,
    OP_Q_FIN_RD,
    OP_Q_FIN_WR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_query;
    logic child_skip;
    logic att_last;
    logic lvl_zero;
    logic diff_bit;
    logic nodes_eq;
    logic out_busy;
  } stat_t;

  // Node numbers at or above the node count read as the root.
  function automatic node_t node_index(input node_t raw);
    return ({1'b0, raw} < (NODE_W + 1)'(NODES)) ? raw : '0;
  endfunction

endpackage

// ===== rtl/core/lca_ifs.sv =====
// Valid/ready channel interfaces for the input and result items of the core.
interface lca_in_if;
  logic              valid;
  logic              ready;
  logic              action;
  lca_pkg::node_t    node_first;
  lca_pkg::node_t    node_second;

  modport source (output valid, output action, output node_first, output node_second,
                  input ready);
  modport sink   (input valid, input action, input node_first, input node_second,
                  output ready);
endinterface

interface lca_out_if;
  logic              valid;
  logic              ready;
  lca_pkg::node_t    ancestor;

  modport source (output valid, output ancestor, input ready);
  modport sink   (input valid, input ancestor, output ready);
endinterface

// ===== rtl/core/lca_binary_lifting_core.sv =====
// Top level of the lowest common ancestor core: a rooted tree kept in ancestor and depth memories.
//
// Input channel in_ch carries one item: action, node_first and node_second.
// An attach item (action 0) hangs node_first under node_second. It gives no
// result and occupies the core while it walks a chain of dependent reads of
// the ancestor memory. An attach of the root is dropped.
// A query item (action 1) returns the lowest common ancestor of its two nodes
// as one item on out_ch. It reads both depths, scans the levels of the depth
// difference and lifts the deeper node at each set bit; unless the lifted node
// already meets the other, a joint lift over all levels and a final step follow.
// Each step waits for one registered read of the ancestor memory, whose address
// is the node that the previous read returned.
// Items are taken one at a time; in_ch.ready is high only between items.
// A finished result sits in an output register, so a new item is accepted
// while it waits; a further result waits inside the core until out_ch.ready.
// Reset clears the control state only. The root row and root depth read as
// zero without any clearing pass; entries of nodes never attached are
// undefined.
module lca_binary_lifting_core (
  input  logic      clk,
  input  logic      rst_n,
  lca_in_if.sink    in_ch,
  lca_out_if.source out_ch
);
  import lca_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lca_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_action      (in_ch.action),
    .in_node_first  (in_ch.node_first),
    .in_node_second (in_ch.node_second),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ancestor   (out_ch.ancestor)
  );

endmodule

// ===== rtl/core/lca_ctrl.sv =====
// Sequencing state machine that steps the datapath through attach and query items.
module lca_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lca_pkg::stat_t stat,
  output lca_pkg::cmd_t  cmd
);
  import lca_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_ATT0    = 15'h0002,
    S_ATT_RD  = 15'h0004,
    S_ATT_WR  = 15'h0008,
    S_ATT_DEP = 15'h0010,
    S_Q_DEP   = 15'h0020,
    S_Q_DIFF  = 15'h0040,
    S_Q_LIFT  = 15'h0080,
    S_Q_LIFTW = 15'h0100,
    S_Q_EQ    = 15'h0200,
    S_Q_UP    = 15'h0400,
    S_Q_UPW   = 15'h0800,
    S_Q_FIN   = 15'h1000,
    S_Q_FINW  = 15'h2000,
    S_OUT     = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = stat.in_query ? S_Q_DEP : S_ATT0;
        end
      end
      S_ATT0: begin
        if (stat.child_skip) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_ATT0;
          state_nxt = (LEVELS == 1) ? S_ATT_DEP : S_ATT_RD;
        end
      end
      S_ATT_RD: begin
        cmd.op    = OP_ATT_RD;
        state_nxt = S_ATT_WR;
      end
      S_ATT_WR: begin
        cmd.op    = OP_ATT_WR;
        state_nxt = stat.att_last ? S_ATT_DEP : S_ATT_RD;
      end
      S_ATT_DEP: begin
        cmd.op    = OP_ATT_DEP;
        state_nxt = S_IDLE;
      end
      S_Q_DEP: begin
        cmd.op    = OP_Q_DEP;
        state_nxt = S_Q_DIFF;
      end
      S_Q_DIFF: begin
        cmd.op    = OP_Q_DIFF;
        state_nxt = S_Q_LIFT;
      end
      S_Q_LIFT: begin
        if (stat.diff_bit) begin
          cmd.op    = OP_Q_LIFT_RD;
          state_nxt = S_Q_LIFTW;
        end else if (stat.lvl_zero) begin
          state_nxt = S_Q_EQ;
        end else begin
          cmd.op = OP_Q_SKIP;
        end
      end
      S_Q_LIFTW: begin
        cmd.op    = OP_Q_LIFT_WR;
        state_nxt = stat.lvl_zero ? S_Q_EQ : S_Q_LIFT;
      end
      S_Q_EQ: begin
        cmd.op    = OP_Q_EQ;
        state_nxt = stat.nodes_eq ? S_OUT : S_Q_UP;
      end
      S_Q_UP: begin
        cmd.op    = OP_Q_UP_RD;
        state_nxt = S_Q_UPW;
      end
      S_Q_UPW: begin
        cmd.op    = OP_Q_UP_WR;
        state_nxt = stat.lvl_zero ? S_Q_FIN : S_Q_UP;
      end
      S_Q_FIN: begin
        cmd.op    = OP_Q_FIN_RD;
        state_nxt = S_Q_FINW;
      end
      S_Q_FINW: begin
        cmd.op    = OP_Q_FIN_WR;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted item did not start a sequence");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_LOAD) |-> (in_valid && in_ready))
    else $error("datapath load without an accepted item");

endmodule

// ===== rtl/core/lca_datapath.sv =====
// Datapath with ancestor and depth memories, node and level registers, and the result register.
module lca_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  lca_pkg::cmd_t  cmd,
  output lca_pkg::stat_t stat,
  input  logic           in_action,
  input  lca_pkg::node_t in_node_first,
  input  lca_pkg::node_t in_node_second,
  input  logic           out_ready,
  output logic           out_valid,
  output lca_pkg::node_t out_ancestor
);
  import lca_pkg::*;

  node_t  anc_mem [ANC_DEPTH];
  depth_t dep_mem [NODES];

  node_t  a_r, b_r, res_r, out_ancestor_r;
  lvl_t   lvl_r;
  depth_t diff_r;
  logic   out_valid_r;

  node_t  anc_rd_a_r, anc_rd_b_r;
  depth_t dep_rd_a_r, dep_rd_b_r;

  logic   anc_we, anc_re_a, anc_re_b;
  node_t  anc_wnode, anc_wdata, anc_node_a, anc_node_b;
  lvl_t   anc_wlvl, anc_lvl_a, anc_lvl_b;
  logic   dep_we, dep_re_a, dep_re_b;
  node_t  dep_node_a, dep_node_b;
  depth_t dep_wdata;

  always_comb begin
    anc_we     = 1'b0;
    anc_wnode  = a_r;
    anc_wlvl   = lvl_r;
    anc_wdata  = anc_rd_a_r;
    anc_re_a   = 1'b0;
    anc_node_a = a_r;
    anc_lvl_a  = lvl_r;
    anc_re_b   = 1'b0;
    anc_node_b = b_r;
    anc_lvl_b  = lvl_r;
    dep_we     = 1'b0;
    dep_wdata  = (dep_rd_a_r == DEPTH_MAX) ? DEPTH_MAX : dep_rd_a_r + depth_t'(1);
    dep_re_a   = 1'b0;
    dep_node_a = a_r;
    dep_re_b   = 1'b0;
    dep_node_b = b_r;
    case (cmd.op)
      OP_ATT0: begin
        anc_we     = 1'b1;
        anc_wlvl   = '0;
        anc_wdata  = b_r;
        dep_re_a   = 1'b1;
        dep_node_a = b_r;
      end
      OP_ATT_RD: begin
        anc_re_a   = 1'b1;
        anc_node_a = b_r;
        anc_lvl_a  = lvl_r - lvl_t'(1);
      end
      OP_ATT_WR: begin
        anc_we = 1'b1;
      end
      OP_ATT_DEP: begin
        dep_we = 1'b1;
      end
      OP_Q_DEP: begin
        dep_re_a = 1'b1;
        dep_re_b = 1'b1;
      end
      OP_Q_LIFT_RD: begin
        anc_re_a = 1'b1;
      end
      OP_Q_UP_RD: begin
        anc_re_a = 1'b1;
        anc_re_b = 1'b1;
      end
      OP_Q_FIN_RD: begin
        anc_re_a  = 1'b1;
        anc_lvl_a = '0;
      end
      default: begin
      end
    endcase
  end

  // The root row and root depth are never written and read back as zero.
  always_ff @(posedge clk) begin
    if (anc_we) begin
      anc_mem[{anc_wnode[NIDX_W-1:0], anc_wlvl}] <= anc_wdata;
    end
    if (anc_re_a) begin
      anc_rd_a_r <= (anc_node_a == '0) ? '0 : anc_mem[{anc_node_a[NIDX_W-1:0], anc_lvl_a}];
    end
    if (anc_re_b) begin
      anc_rd_b_r <= (anc_node_b == '0) ? '0 : anc_mem[{anc_node_b[NIDX_W-1:0], anc_lvl_b}];
    end
  end

  always_ff @(posedge clk) begin
    if (dep_we) begin
      dep_mem[a_r[NIDX_W-1:0]] <= dep_wdata;
    end
    if (dep_re_a) begin
      dep_rd_a_r <= (dep_node_a == '0) ? '0 : dep_mem[dep_node_a[NIDX_W-1:0]];
    end
    if (dep_re_b) begin
      dep_rd_b_r <= (dep_node_b == '0) ? '0 : dep_mem[dep_node_b[NIDX_W-1:0]];
    end
  end

  logic act_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        act_r <= in_action;
        a_r   <= node_index(in_node_first);
        b_r   <= node_index(in_node_second);
      end
      OP_ATT0: begin
        lvl_r <= lvl_t'(1);
      end
      OP_ATT_WR: begin
        b_r   <= anc_rd_a_r;
        lvl_r <= lvl_r + lvl_t'(1);
      end
      OP_Q_DIFF: begin
        if (dep_rd_a_r < dep_rd_b_r) begin
          a_r    <= b_r;
          b_r    <= a_r;
          diff_r <= dep_rd_b_r - dep_rd_a_r;
        end else begin
          diff_r <= dep_rd_a_r - dep_rd_b_r;
        end
        lvl_r <= lvl_t'(LEVELS - 1);
      end
      OP_Q_LIFT_WR: begin
        a_r   <= anc_rd_a_r;
        lvl_r <= lvl_r - lvl_t'(1);
      end
      OP_Q_SKIP: begin
        lvl_r <= lvl_r - lvl_t'(1);
      end
      OP_Q_EQ: begin
        res_r <= a_r;
        lvl_r <= lvl_t'(LEVELS - 1);
      end
      OP_Q_UP_WR: begin
        if (anc_rd_a_r != anc_rd_b_r) begin
          a_r <= anc_rd_a_r;
          b_r <= anc_rd_b_r;
        end
        lvl_r <= lvl_r - lvl_t'(1);
      end
      OP_Q_FIN_WR: begin
        res_r <= anc_rd_a_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ancestor_r <= res_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ancestor = out_ancestor_r;

  always_comb begin
    stat.in_query   = (in_action == ACT_QUERY);
    stat.child_skip = (a_r == '0) || (act_r == ACT_QUERY);
    stat.att_last   = (lvl_r == lvl_t'(LEVELS - 1));
    stat.lvl_zero   = (lvl_r == '0);
    stat.diff_bit   = diff_r[lvl_r];
    stat.nodes_eq   = (a_r == b_r);
    stat.out_busy   = out_valid_r && !out_ready;
  end

  a_row_loop_skips_level0: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_ATT_WR) |-> (lvl_r != '0))
    else $error("ancestor row loop overwrote the parent entry");

  a_joint_lift_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_Q_FIN_WR) |-> (a_r != b_r))
    else $error("joint lift met at a common node");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && !out_ready))
    else $error("result loaded while the previous one was still waiting");

endmodule
